// ===== hw/rtl/scaw_pkg.sv =====
`default_nettype none

package scaw_pkg;

    // Field widths of the stream payloads.
    localparam int WORD_W   = 16;
    localparam int POS_W    = 10;   // scaled position of one entry
    localparam int HELD_W   = 11;   // held and drawn positions
    localparam int SUM_W    = 12;   // one guard bit for add and mirror
    localparam int COLOR_W  = 6;
    localparam int LIMIT_W  = 10;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPRITE_FORMAT   = 3'd0,
        REG_SCREEN_FLIP     = 3'd1,
        REG_PRIORITY_SELECT = 3'd2,
        REG_FLIP_LIMIT_X    = 3'd3,
        REG_FLIP_LIMIT_Y    = 3'd4
    } cfg_index_t;

    localparam logic              FORMAT_OLD     = 1'b0;
    localparam logic              RST_FORMAT     = 1'b1;
    localparam logic [1:0]        RST_FLIP       = 2'd0;
    localparam logic [1:0]        RST_PRIORITY   = 2'd0;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_X   = 10'd303;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_Y   = 10'd223;

    // Bits 15..13 of the attribute all set mark a chained entry.
    localparam logic [WORD_W-1:0] MULTI_MASK = 16'he000;

    typedef struct packed {
        logic                sprite_format;
        logic [1:0]          screen_flip;
        logic [1:0]          priority_select;
        logic [LIMIT_W-1:0]  flip_limit_x;
        logic [LIMIT_W-1:0]  flip_limit_y;
    } cfg_t;

    typedef struct packed {
        logic                     first;
        logic                     chain;
        logic [WORD_W-1:0]        attr;
        logic [WORD_W-1:0]        code;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
    } entry_t;

    typedef struct packed {
        logic signed [HELD_W-1:0] x;
        logic signed [HELD_W-1:0] y;
        logic [WORD_W-1:0]        code;
        logic [WORD_W-1:0]        attr;
        logic                     flip_x;
        logic                     flip_y;
    } held_t;

    typedef struct packed {
        logic [WORD_W-1:0]        code;
        logic [COLOR_W-1:0]       color;
        logic                     flip_x;
        logic                     flip_y;
        logic signed [HELD_W-1:0] draw_x;
        logic signed [HELD_W-1:0] draw_y;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scaw_entry_decode.sv =====
`default_nettype none

module scaw_entry_decode
(
    input  wire logic                          first_entry,
    input  wire logic [scaw_pkg::WORD_W-1:0]   attr_word,
    input  wire logic [scaw_pkg::WORD_W-1:0]   code_word,
    input  wire logic [scaw_pkg::WORD_W-1:0]   xpos_word,
    input  wire logic [scaw_pkg::WORD_W-1:0]   ypos_word,
    input  wire logic                          sprite_format,
    output scaw_pkg::entry_t                   entry
);

    logic [scaw_pkg::WORD_W-1:0] attr_new;

    // Divide a signed word by 64, rounding toward zero: bias negatives by 63
    // before the arithmetic shift. The biased value cannot overflow.
    function automatic logic signed [scaw_pkg::POS_W-1:0] scale_pos(
        input logic [scaw_pkg::WORD_W-1:0] w
    );
        logic signed [scaw_pkg::WORD_W-1:0] biased;
        biased = $signed(w) + (w[scaw_pkg::WORD_W-1] ? 16'sd63 : 16'sd0);
        return biased[scaw_pkg::WORD_W-1:scaw_pkg::WORD_W-scaw_pkg::POS_W];
    endfunction

    always_comb
    begin
        if (sprite_format == scaw_pkg::FORMAT_OLD)
        begin
            // Older layout: flips sit in the two low bits, priority and
            // color two places higher.
            attr_new = {attr_word[15:10], attr_word[1:0], attr_word[9:2]};
        end
        else
        begin
            attr_new = attr_word;
        end
    end

    always_comb
    begin
        entry.first = first_entry;
        entry.chain = (attr_new & scaw_pkg::MULTI_MASK) == scaw_pkg::MULTI_MASK;
        entry.attr  = attr_new;
        entry.code  = code_word;
        entry.x     = scale_pos(xpos_word);
        entry.y     = scale_pos(ypos_word);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scaw_chain_state.sv =====
`default_nettype none

module scaw_chain_state
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire scaw_pkg::entry_t  entry,
    output scaw_pkg::held_t        held_next
);

    scaw_pkg::held_t held_reg;
    scaw_pkg::held_t base;

    // Chained positions saturate symmetrically at +/-1023.
    function automatic logic signed [scaw_pkg::HELD_W-1:0] clamp_held(
        input logic signed [scaw_pkg::SUM_W-1:0] v
    );
        if (v > 12'sd1023)
            return 11'sd1023;
        else if (v < -12'sd1023)
            return -11'sd1023;
        else
            return v[scaw_pkg::HELD_W-1:0];
    endfunction

    always_comb
    begin
        base = entry.first ? '0 : held_reg;
        held_next = base;
        if (entry.chain)
        begin
            held_next.x = clamp_held({base.x[scaw_pkg::HELD_W-1], base.x}
                + {{(scaw_pkg::SUM_W-scaw_pkg::POS_W){entry.x[scaw_pkg::POS_W-1]}}, entry.x});
            held_next.y = clamp_held({base.y[scaw_pkg::HELD_W-1], base.y}
                + {{(scaw_pkg::SUM_W-scaw_pkg::POS_W){entry.y[scaw_pkg::POS_W-1]}}, entry.y});
            held_next.code = base.code + 16'd1;
        end
        else
        begin
            held_next.x = {entry.x[scaw_pkg::POS_W-1], entry.x};
            held_next.y = {entry.y[scaw_pkg::POS_W-1], entry.y};
            held_next.code   = entry.code;
            held_next.attr   = entry.attr;
            held_next.flip_x = entry.attr[9];
            held_next.flip_y = entry.attr[8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (advance)
        begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scaw_screen_mirror.sv =====
`default_nettype none

module scaw_screen_mirror
(
    input  wire scaw_pkg::held_t  held,
    input  wire scaw_pkg::cfg_t   cfg,
    output logic                  emit,
    output scaw_pkg::result_t     result
);

    // limit - pos lies in -1023..2046; only the top end can clip in practice.
    function automatic logic signed [scaw_pkg::HELD_W-1:0] mirror_pos(
        input logic [scaw_pkg::LIMIT_W-1:0]       limit,
        input logic signed [scaw_pkg::HELD_W-1:0] pos
    );
        logic signed [scaw_pkg::SUM_W-1:0] d;
        d = $signed({2'b00, limit}) - $signed({pos[scaw_pkg::HELD_W-1], pos});
        if (d > 12'sd1023)
            return 11'sd1023;
        else if (d < -12'sd1024)
            return -11'sd1024;
        else
            return d[scaw_pkg::HELD_W-1:0];
    endfunction

    always_comb
    begin
        emit = held.attr[7:6] == cfg.priority_select;

        result.code   = held.code;
        result.color  = held.attr[scaw_pkg::COLOR_W-1:0];
        result.flip_x = held.flip_x ^ cfg.screen_flip[1];
        result.flip_y = held.flip_y ^ cfg.screen_flip[0];
        result.draw_x = cfg.screen_flip[1] ? mirror_pos(cfg.flip_limit_x, held.x) : held.x;
        result.draw_y = cfg.screen_flip[0] ? mirror_pos(cfg.flip_limit_y, held.y) : held.y;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sprite_chain_attribute_walker_unit.sv =====
`default_nettype none

// Sprite chain walker: takes one four-word sprite list entry per transfer on
// the s_ stream and returns at most one draw command per entry on the m_
// stream, in order. An entry whose top three attribute bits are set continues
// a multisprite chain (offset added to the held position, code incremented);
// any other entry starts a new chain. A draw command appears only when bits
// 7..6 of the held attribute equal priority_select, so entries of other
// priorities are absorbed silently while still updating the chain. Setting
// s_tuser on an entry clears the chain before it is handled; use it on the
// first entry of every list pass. The block sustains one entry per clock:
// an entry is captured in the input register, and as it leaves that register
// the chain registers update and the draw command is loaded into the output
// register, which drives m_tvalid and m_tdata. The only stall is a full
// output register whose command is not taken, and only an entry that
// produces a command waits for it. Configuration registers are written
// through cfg_write/cfg_index/cfg_wdata and must only change while no entry
// is in flight.

module sprite_chain_attribute_walker_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // attr_word [15:0], code_word [31:16], xpos_word [47:32], ypos_word [63:48]
    input  wire logic [scaw_pkg::IN_DATA_W-1:0]     s_tdata,
    // first_entry [0]
    input  wire logic                               s_tuser,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // sprite_code [15:0], sprite_color [21:16], sprite_flip_x [22],
    // sprite_flip_y [23], draw_x [34:24], draw_y [45:35], zero [47:46]
    output logic [scaw_pkg::OUT_DATA_W-1:0]         m_tdata,

    input  wire logic                               cfg_write,
    input  wire logic [scaw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [scaw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    scaw_pkg::cfg_t             cfg_reg;

    // Input register.
    logic                       in_valid_reg;
    logic                       in_first_reg;
    logic [scaw_pkg::IN_DATA_W-1:0] in_data_reg;

    // Output register.
    logic                       out_valid_reg;
    logic [scaw_pkg::OUT_DATA_W-1:0] out_data_reg;

    scaw_pkg::entry_t           entry;
    scaw_pkg::held_t            held_next;
    scaw_pkg::result_t          result;
    logic                       emit;
    logic                       out_free;
    logic                       advance;
    logic                       in_take;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sprite_format   <= scaw_pkg::RST_FORMAT;
            cfg_reg.screen_flip     <= scaw_pkg::RST_FLIP;
            cfg_reg.priority_select <= scaw_pkg::RST_PRIORITY;
            cfg_reg.flip_limit_x    <= scaw_pkg::RST_LIMIT_X;
            cfg_reg.flip_limit_y    <= scaw_pkg::RST_LIMIT_Y;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                scaw_pkg::REG_SPRITE_FORMAT:   cfg_reg.sprite_format   <= cfg_wdata[0];
                scaw_pkg::REG_SCREEN_FLIP:     cfg_reg.screen_flip     <= cfg_wdata[1:0];
                scaw_pkg::REG_PRIORITY_SELECT: cfg_reg.priority_select <= cfg_wdata[1:0];
                scaw_pkg::REG_FLIP_LIMIT_X:    cfg_reg.flip_limit_x    <= cfg_wdata;
                scaw_pkg::REG_FLIP_LIMIT_Y:    cfg_reg.flip_limit_y    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    scaw_entry_decode u_decode
    (
        .first_entry   (in_first_reg),
        .attr_word     (in_data_reg[15:0]),
        .code_word     (in_data_reg[31:16]),
        .xpos_word     (in_data_reg[47:32]),
        .ypos_word     (in_data_reg[63:48]),
        .sprite_format (cfg_reg.sprite_format),
        .entry         (entry)
    );

    scaw_chain_state u_chain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .entry     (entry),
        .held_next (held_next)
    );

    scaw_screen_mirror u_mirror
    (
        .held   (held_next),
        .cfg    (cfg_reg),
        .emit   (emit),
        .result (result)
    );

    // An entry that draws nothing never waits for the output side.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_first_reg <= s_tuser;
            in_data_reg  <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= {2'b00, result.draw_y, result.draw_x, result.flip_y,
                             result.flip_x, result.color, result.code};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scaw_checker.sv =====
`default_nettype none

module scaw_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [scaw_pkg::OUT_DATA_W-1:0]   m_tdata
);

    // A command that is not taken stays, unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled draw command changed or vanished");

    // A command leaves only through a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
    else $error("draw command dropped without transfer");

    // With room on the output side the input side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled although output can move");

    // Padding bits above draw_y are zero whenever a command is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47:46] == 2'b00)
    else $error("padding bits of draw command set");

endmodule

bind sprite_chain_attribute_walker_unit scaw_checker u_scaw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/sprite_chain_attribute_walker_unit_test.sv =====
`default_nettype none

module sprite_chain_attribute_walker_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import scaw_pkg::*;

    // Run shape.
    localparam int RESET_CYCLES    = 8;
    localparam int IDLE_PERCENT    = 13;
    localparam int PHASE_ENTRIES   = 228;
    localparam int PRESSURE_CYCLES = 400;
    localparam int DRAIN_LIMIT     = 5000;
    // Two register stages sit between the input and output transfers, so once
    // the settle wait after the last draw command ends nothing can still be in flight.
    localparam int SETTLE_CYCLES   = 6;
    localparam int MAX_REPORTS     = 10;
    localparam longint TIMEOUT_NS  = 2_000_000;

    // Register indexes at and above this one address nothing.
    localparam int NUM_REGS = 5;

    // Behavior constants of the walker.
    localparam int POS_SCALE = 64;       // position words carry six fraction bits
    localparam int HELD_MAX  = 1023;     // chained positions saturate at +/- this
    localparam int DRAW_MIN  = -1024;    // mirrored coordinates saturate to
    localparam int DRAW_MAX  = 1023;     // the full 11-bit signed range
    localparam int MIRROR_X_BIT = 1;     // screen_flip bit that mirrors x
    localparam int MIRROR_Y_BIT = 0;     // screen_flip bit that mirrors y

    // Scoreboard: keeps its own copy of the configuration registers and of
    // the chain state, predicts the draw command of every accepted entry and
    // compares the commands coming out of the block against that prediction.
    class draw_command_scoreboard;
        logic              sprite_format;
        logic [1:0]        screen_flip;
        logic [1:0]        priority_select;
        int                limit_x;
        int                limit_y;
        int                held_x;
        int                held_y;
        logic [WORD_W-1:0] held_code;
        logic [WORD_W-1:0] held_attr;
        logic              held_flip_x;
        logic              held_flip_y;
        result_t           expected_draws[$];
        int                failures;

        function new();
            sprite_format   = RST_FORMAT;
            screen_flip     = RST_FLIP;
            priority_select = RST_PRIORITY;
            limit_x         = int'(RST_LIMIT_X);
            limit_y         = int'(RST_LIMIT_Y);
            failures        = 0;
            clear_chain();
        endfunction

        function void clear_chain();
            held_x      = 0;
            held_y      = 0;
            held_code   = '0;
            held_attr   = '0;
            held_flip_x = 1'b0;
            held_flip_y = 1'b0;
        endfunction

        function int saturate(int value, int lo, int hi);
            if (value < lo)
                return lo;
            if (value > hi)
                return hi;
            return value;
        endfunction

        function void report(string text);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("ERROR at %0t: %s", $time, text);
        endfunction

        // Unknown indexes and the unused upper data bits are ignored.
        function void set_register(logic [CFG_INDEX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_SPRITE_FORMAT:   sprite_format   = value[0];
                REG_SCREEN_FLIP:     screen_flip     = value[1:0];
                REG_PRIORITY_SELECT: priority_select = value[1:0];
                REG_FLIP_LIMIT_X:    limit_x         = int'(value[LIMIT_W-1:0]);
                REG_FLIP_LIMIT_Y:    limit_y         = int'(value[LIMIT_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_entry(logic first, logic [WORD_W-1:0] raw_attr,
                                 logic [WORD_W-1:0] code, logic [WORD_W-1:0] xword,
                                 logic [WORD_W-1:0] yword);
            logic [WORD_W-1:0] attr;
            logic signed [WORD_W-1:0] sx;
            logic signed [WORD_W-1:0] sy;
            int step_x;
            int step_y;
            int out_x;
            int out_y;
            result_t cmd;

            // Signed division in SystemVerilog truncates toward zero.
            sx = xword;
            sy = yword;
            step_x = int'(sx) / POS_SCALE;
            step_y = int'(sy) / POS_SCALE;

            if (first)
                clear_chain();

            // The older layout keeps its flip bits at the bottom and the
            // priority and color field two bits higher.
            attr = raw_attr;
            if (sprite_format == FORMAT_OLD)
                attr = {raw_attr[15:10], raw_attr[1:0], raw_attr[9:2]};

            if ((attr & MULTI_MASK) == MULTI_MASK)
            begin
                held_x    = saturate(held_x + step_x, -HELD_MAX, HELD_MAX);
                held_y    = saturate(held_y + step_y, -HELD_MAX, HELD_MAX);
                held_code = held_code + 1'b1;
            end
            else
            begin
                held_x      = step_x;
                held_y      = step_y;
                held_code   = code;
                held_attr   = attr;
                held_flip_x = attr[9];
                held_flip_y = attr[8];
            end

            // Other priorities update the chain but draw nothing this pass.
            if (held_attr[7:6] != priority_select)
                return;

            out_x = held_x;
            out_y = held_y;
            cmd.flip_x = held_flip_x;
            cmd.flip_y = held_flip_y;
            if (screen_flip[MIRROR_X_BIT])
            begin
                out_x = saturate(limit_x - held_x, DRAW_MIN, DRAW_MAX);
                cmd.flip_x = ~cmd.flip_x;
            end
            if (screen_flip[MIRROR_Y_BIT])
            begin
                out_y = saturate(limit_y - held_y, DRAW_MIN, DRAW_MAX);
                cmd.flip_y = ~cmd.flip_y;
            end
            cmd.code   = held_code;
            cmd.color  = held_attr[COLOR_W-1:0];
            cmd.draw_x = HELD_W'(out_x);
            cmd.draw_y = HELD_W'(out_y);
            expected_draws.push_back(cmd);
        endfunction

        function void check_command(logic [OUT_DATA_W-1:0] data);
            result_t got;
            result_t want;

            got.code   = data[15:0];
            got.color  = data[21:16];
            got.flip_x = data[22];
            got.flip_y = data[23];
            got.draw_x = data[34:24];
            got.draw_y = data[45:35];

            if (expected_draws.size() == 0)
            begin
                report($sformatf("draw command %h arrived with none expected", data));
                return;
            end
            want = expected_draws.pop_front();
            if (got.code !== want.code || got.color !== want.color ||
                got.flip_x !== want.flip_x || got.flip_y !== want.flip_y ||
                got.draw_x !== want.draw_x || got.draw_y !== want.draw_y)
                report($sformatf({"draw command mismatch: expected code %h color %h ",
                                  "flips %b%b at (%0d,%0d), got code %h color %h ",
                                  "flips %b%b at (%0d,%0d)"},
                                 want.code, want.color, want.flip_x, want.flip_y,
                                 want.draw_x, want.draw_y, got.code, got.color,
                                 got.flip_x, got.flip_y, got.draw_x, got.draw_y));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    draw_command_scoreboard board = new();

    // When calm is set neither side idles; hold_cycles asks the receiver to
    // refuse draw commands while it counts down.
    logic calm;
    int   hold_cycles;

    sprite_chain_attribute_walker_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Every draw command transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_command(m_tdata);
    end

    // The receiver decides its ready at each falling edge. A pending
    // hold-off is counted down here, one cycle at a time, while the sender
    // keeps offering entries so the block fills up and stalls its input.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Offers one sprite list entry and waits for its transfer. Called and
    // returns at a falling edge; valid is left high so back-to-back entries
    // keep the stream full.
    task automatic send_entry(input logic first, input logic [WORD_W-1:0] attr,
                              input logic [WORD_W-1:0] code,
                              input logic [WORD_W-1:0] xword,
                              input logic [WORD_W-1:0] yword);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {yword, xword, code, attr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_entry(first, attr, code, xword, yword);
        @(negedge clk);
    endtask

    // Half of the positions are short steps of up to 32 pixels, the rest
    // span the whole word and drive chains into saturation.
    function automatic logic [WORD_W-1:0] random_position();
        if ($urandom_range(0, 1) == 0)
            return WORD_W'($urandom);
        return WORD_W'($urandom_range(0, 4095) - 2048);
    endfunction

    // Drops valid, waits for every predicted command, then lets the entries
    // that draw nothing leave the pipeline too.
    task automatic wait_until_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (board.expected_draws.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (board.expected_draws.size() != 0)
        begin
            board.report($sformatf("%0d draw commands never arrived",
                                   board.expected_draws.size()));
            board.expected_draws.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write per cycle; the enable is left high, and configure drops it after the last.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        board.set_register(index, value);
    endtask

    // Writes all five registers with random junk in the unused upper data
    // bits, then pokes the unused indexes, which must change nothing.
    task automatic configure(input logic fmt, input logic [1:0] flip,
                             input logic [1:0] prio, input logic [LIMIT_W-1:0] lim_x,
                             input logic [LIMIT_W-1:0] lim_y);
        write_register(REG_SPRITE_FORMAT, {(CFG_DATA_W-1)'($urandom), fmt});
        write_register(REG_SCREEN_FLIP, {(CFG_DATA_W-2)'($urandom), flip});
        write_register(REG_PRIORITY_SELECT, {(CFG_DATA_W-2)'($urandom), prio});
        write_register(REG_FLIP_LIMIT_X, lim_x);
        write_register(REG_FLIP_LIMIT_Y, lim_y);
        for (int idx = NUM_REGS; idx < (1 << CFG_INDEX_W); idx++)
            write_register(CFG_INDEX_W'(idx), CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly well-formed chains: a head entry that usually carries the
    // selected priority, followed by up to seven chained entries. The rest
    // are raw noise entries with every field random.
    task automatic run_random_entries(input int count);
        int sent;
        int links;
        logic [WORD_W-1:0] attr;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                attr = WORD_W'($urandom);
                if ((attr & MULTI_MASK) == MULTI_MASK)
                    attr[13] = 1'b0;
                if ($urandom_range(0, 99) < 80)
                begin
                    // The priority field sits two bits higher in the old layout.
                    if (board.sprite_format == FORMAT_OLD)
                        attr[9:8] = board.priority_select;
                    else
                        attr[7:6] = board.priority_select;
                end
                send_entry($urandom_range(0, 9) == 0, attr, WORD_W'($urandom),
                           random_position(), random_position());
                links = $urandom_range(0, 7);
                repeat (links)
                    send_entry($urandom_range(0, 29) == 0,
                               MULTI_MASK | WORD_W'($urandom), WORD_W'($urandom),
                               random_position(), random_position());
                sent += links + 1;
            end
            else
            begin
                send_entry(1'($urandom), WORD_W'($urandom), WORD_W'($urandom),
                           WORD_W'($urandom), WORD_W'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = 1'b0;
        s_tdata     = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        calm        = 1'b0;
        hold_cycles = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed entries under the reset configuration: newer layout, no
        // mirroring, priority zero.
        // All-zero entry at the start of a pass.
        send_entry(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // Chained entries with the largest steps: x climbs to +1023 and y
        // falls to -1023, both saturating.
        send_entry(1'b0, 16'he000, 16'h1234, 16'h7fff, 16'h8000);
        send_entry(1'b0, 16'hffff, 16'hffff, 16'h7fff, 16'h8000);
        send_entry(1'b0, 16'he000, 16'h0000, 16'h7fff, 16'h8000);
        // Small negative steps truncate toward zero and leave the position.
        send_entry(1'b0, 16'he000, 16'h0000, 16'hffff, 16'hffc1);
        // New chain with both flips, then code wrap from ffff to zero.
        send_entry(1'b0, 16'h0300, 16'hffff, 16'hffc0, 16'h0040);
        send_entry(1'b0, 16'he000, 16'h0000, 16'hffc0, 16'h0040);
        // Priority mismatch: no command, but the chain still advances.
        send_entry(1'b0, 16'h00c0, 16'h4321, 16'h0100, 16'h0100);
        send_entry(1'b0, 16'he000, 16'h0000, 16'h0100, 16'h0100);
        // Chained entry at the start of a pass builds on a cleared chain.
        send_entry(1'b1, 16'hffff, 16'haaaa, 16'h0100, 16'hff00);
        // Top bits 110 and 101 start a new chain; full color and both flips.
        send_entry(1'b0, 16'hdf3f, 16'h5555, 16'h8000, 16'h7fff);
        send_entry(1'b0, 16'hbc00, 16'h0001, 16'h0040, 16'hffc0);
        wait_until_idle();

        // Old layout, both mirrors at the far limit, priority three. The
        // receiver stalls for a long stretch at the start of this phase.
        configure(FORMAT_OLD, 2'd3, 2'd3, 10'd1023, 10'd1023);
        hold_cycles = PRESSURE_CYCLES;
        run_random_entries(PHASE_ENTRIES);
        wait_until_idle();

        configure(1'b1, 2'd2, 2'd1, 10'd0, 10'd1023);
        run_random_entries(PHASE_ENTRIES);
        wait_until_idle();

        configure(FORMAT_OLD, 2'd1, 2'd2, 10'd1023, 10'd0);
        run_random_entries(PHASE_ENTRIES);
        wait_until_idle();

        // Mirror saturation: x walks down to -1023 against limit 1023 and y
        // climbs to +1023 against limit zero. Neither side idles here.
        calm = 1'b1;
        configure(1'b1, 2'd3, 2'd0, 10'd1023, 10'd0);
        send_entry(1'b1, 16'h0000, 16'h0010, 16'h8000, 16'h7fff);
        send_entry(1'b0, 16'he000, 16'h0000, 16'h8000, 16'h7fff);
        send_entry(1'b0, 16'he000, 16'h0000, 16'h8000, 16'h7fff);
        run_random_entries(PHASE_ENTRIES);
        wait_until_idle();
        calm = 1'b0;

        configure(FORMAT_OLD, 2'd0, 2'd1, LIMIT_W'($urandom), LIMIT_W'($urandom));
        run_random_entries(PHASE_ENTRIES);
        wait_until_idle();

        configure(1'b1, 2'd3, 2'd2, LIMIT_W'($urandom), LIMIT_W'($urandom));
        hold_cycles = PRESSURE_CYCLES;
        run_random_entries(PHASE_ENTRIES);
        wait_until_idle();

        configure(FORMAT_OLD, 2'd2, 2'd0, 10'd0, 10'd0);
        run_random_entries(PHASE_ENTRIES);
        wait_until_idle();

        // Back to the reset values.
        configure(RST_FORMAT, RST_FLIP, RST_PRIORITY, RST_LIMIT_X, RST_LIMIT_Y);
        run_random_entries(PHASE_ENTRIES);
        wait_until_idle();

        if (board.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guards against a block that stops moving.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
